>>> rtl/core/joystick_delta_deadzone_scale_macros.svh
// Assertion macros for the joystick delta block.
// Included by the top level; no other dependencies.
`ifndef JOYSTICK_DELTA_DEADZONE_SCALE_MACROS_SVH
`define JOYSTICK_DELTA_DEADZONE_SCALE_MACROS_SVH
`ifndef SYNTHESIS
`define JDDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define JDDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JDDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define JDDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/jdds_pkg.sv
// Shared types and constants of the joystick delta block.
// No dependencies; used by jdds_axis and the top level.
package jdds_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_S0_MIN_X = 3'd0,
        REG_S0_MAX_X = 3'd1,
        REG_S0_MIN_Y = 3'd2,
        REG_S0_MAX_Y = 3'd3,
        REG_S1_MIN_X = 3'd4,
        REG_S1_MAX_X = 3'd5,
        REG_S1_MIN_Y = 3'd6,
        REG_S1_MAX_Y = 3'd7
    } cfg_reg_e;

    localparam logic [POS_W-1:0] MIN_RESET = 16'd0;
    localparam logic [POS_W-1:0] MAX_RESET = 16'd2048;

    // floor(n/3) == (n * RECIP3) >> RECIP3_SHIFT for every 16-bit n
    localparam logic [16:0]      RECIP3       = 17'h0AAAB;
    localparam int               RECIP3_SHIFT = 17;
    localparam logic [7:0]       DELTA_LIMIT  = 8'd127;

    // 0x8000 / span: 16 quotient bits, two per stage
    localparam int DIV_STAGES = 8;
    localparam int AXIS_LATENCY = 4 + DIV_STAGES + 2;

    typedef struct packed {
        logic             stick_select;
        logic [POS_W-1:0] raw_x;
        logic [POS_W-1:0] raw_y;
    } in_t;

    typedef struct packed {
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
    } out_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } axis_in_t;

endpackage

>>> rtl/core/jdds_axis.sv
// One axis of the joystick delta pipeline: dead zone, scale divide, multiply, saturate.
// Depends on jdds_pkg. The pipeline advances only while en is high.
module jdds_axis #(
    parameter int SCALE_SHIFT = 8
) (
    input  logic               clk,
    input  logic               en,
    input  jdds_pkg::axis_in_t axis_in,
    output logic signed [7:0]  delta
);
    import jdds_pkg::*;

    // returns {quotient bit, remainder}
    function automatic logic [16:0] div_step(logic [15:0] rem, logic [15:0] span,
                                             logic nbit);
        logic [16:0] t;
        logic [16:0] diff;
        t    = {rem, nbit};
        diff = t - {1'b0, span};
        if (t >= {1'b0, span})
            return {1'b1, diff[15:0]};
        else
            return {1'b0, t[15:0]};
    endfunction

    // stage 1: range
    logic [15:0] pos1_reg, lo1_reg, hi1_reg, r1_reg;
    // stage 2: third of the range
    logic [15:0] pos2_reg, lo2_reg, hi2_reg, r2_reg, d2_reg;
    logic [32:0] d_prod;
    // stage 3: thresholds
    logic [15:0] pos3_reg, lo3_reg, hi3_reg, tmin3_reg, tmax3_reg;
    // stage 4: zone, distance, span
    logic [15:0] dist4_next, span4_next, dist4_reg, span4_reg;
    logic        neg4_next, neg4_reg;
    logic [15:0] pos_clamped;
    // divider stages
    logic [15:0] rem_reg [DIV_STAGES];
    logic [15:0] quo_reg [DIV_STAGES];
    logic [15:0] span_reg [DIV_STAGES];
    logic [15:0] dist_reg [DIV_STAGES];
    logic        neg_reg [DIV_STAGES];
    logic [15:0] rem_next [DIV_STAGES];
    logic [15:0] quo_next [DIV_STAGES];
    // multiply and saturate
    logic [15:0] scale;
    logic [31:0] prod;
    logic [15:0] prod_reg;
    logic        negm_reg;
    logic [15:0] shifted;
    logic [7:0]  mag;
    logic [7:0]  delta_next;
    logic signed [7:0] delta_reg;

    assign d_prod = r1_reg * RECIP3;

    always_comb
    begin
        dist4_next  = '0;
        span4_next  = '0;
        neg4_next   = 1'b0;
        pos_clamped = pos3_reg;
        if (pos3_reg < tmin3_reg)
        begin
            pos_clamped = (pos3_reg < lo3_reg) ? lo3_reg : pos3_reg;
            dist4_next  = tmin3_reg - pos_clamped;
            span4_next  = tmin3_reg - lo3_reg;
            neg4_next   = 1'b1;
        end
        else if (pos3_reg > tmax3_reg)
        begin
            pos_clamped = (pos3_reg > hi3_reg) ? hi3_reg : pos3_reg;
            dist4_next  = pos_clamped - tmax3_reg;
            span4_next  = hi3_reg - tmax3_reg;
        end
    end

    // two restoring steps per stage; the numerator 0x8000 feeds a one only on the first step
    always_comb
    begin
        logic [15:0] rem_in;
        logic [15:0] quo_in;
        logic [15:0] span_in;
        logic [16:0] st0;
        logic [16:0] st1;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem_in  = '0;
                quo_in  = '0;
                span_in = span4_reg;
            end
            else
            begin
                rem_in  = rem_reg[s-1];
                quo_in  = quo_reg[s-1];
                span_in = span_reg[s-1];
            end
            st0 = div_step(rem_in, span_in, 1'(s == 0));
            st1 = div_step(st0[15:0], span_in, 1'b0);
            rem_next[s] = st1[15:0];
            quo_next[s] = {quo_in[13:0], st0[16], st1[16]};
        end
    end

    assign scale = (span_reg[DIV_STAGES-1] == '0) ? '0 : quo_reg[DIV_STAGES-1];
    assign prod  = dist_reg[DIV_STAGES-1] * scale;

    assign shifted    = prod_reg >> SCALE_SHIFT;
    assign mag        = (shifted > 16'(DELTA_LIMIT)) ? DELTA_LIMIT : shifted[7:0];
    assign delta_next = negm_reg ? (8'd0 - mag) : mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos1_reg  <= axis_in.pos;
            lo1_reg   <= axis_in.lo;
            hi1_reg   <= axis_in.hi;
            r1_reg    <= axis_in.hi - axis_in.lo;

            pos2_reg  <= pos1_reg;
            lo2_reg   <= lo1_reg;
            hi2_reg   <= hi1_reg;
            r2_reg    <= r1_reg;
            d2_reg    <= d_prod[RECIP3_SHIFT +: 16];

            pos3_reg  <= pos2_reg;
            lo3_reg   <= lo2_reg;
            hi3_reg   <= hi2_reg;
            tmin3_reg <= (r2_reg >> 1) - d2_reg + lo2_reg;
            tmax3_reg <= (r2_reg >> 1) + d2_reg + lo2_reg;

            dist4_reg <= dist4_next;
            span4_reg <= span4_next;
            neg4_reg  <= neg4_next;

            span_reg[0] <= span4_reg;
            dist_reg[0] <= dist4_reg;
            neg_reg[0]  <= neg4_reg;
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
            end
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                span_reg[s] <= span_reg[s-1];
                dist_reg[s] <= dist_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
            end

            prod_reg  <= prod[15:0];
            negm_reg  <= neg_reg[DIV_STAGES-1];

            delta_reg <= delta_next;
        end
    end

    assign delta = delta_reg;

endmodule

>>> rtl/core/joystick_delta_deadzone_scale.sv
// Top level of the joystick delta block: calibration registers, valid pipeline, two axes.
// Depends on jdds_pkg, jdds_axis and joystick_delta_deadzone_scale_macros.svh.
//
// Usage:
//   Input beats (stick_select, raw_x, raw_y) enter on in_valid while in_stall is low.
//   Each beat yields one output beat (delta_x, delta_y) on out_valid/out_stall.
//   The pipeline has four stages for range, third, thresholds and zone,
//   eight stages of the 0x8000 / span divider (two quotient bits each), one
//   multiply stage and one saturate stage whose register drives out_data.
//   Throughput is one beat per cycle while the output is not stalled; the divider pipeline sets the depth.
//   When the receiver stalls a valid output, every stage holds and in_stall
//   rises in the same cycle; nothing is dropped or repeated.
//   Calibration registers are written through cfg_wr_en/cfg_index/cfg_data. The user
//   must write only while no beat is in flight; the block does not check. Reset empties
//   the pipeline and loads the calibration defaults (min 0, max 2048 on every axis).
`include "joystick_delta_deadzone_scale_macros.svh"
module joystick_delta_deadzone_scale #(
    parameter int SCALE_SHIFT = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  jdds_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output jdds_pkg::out_t                      out_data,
    input  logic                                cfg_wr_en,
    input  logic [jdds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jdds_pkg::POS_W-1:0]          cfg_data
);
    import jdds_pkg::*;

    logic [POS_W-1:0]        cfg_reg [NUM_REGS];
    logic [AXIS_LATENCY-1:0] valid_reg;
    logic                    adv;
    axis_in_t                x_in, y_in;
    logic signed [7:0]       dx, dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_S0_MIN_X] <= MIN_RESET;
            cfg_reg[REG_S0_MAX_X] <= MAX_RESET;
            cfg_reg[REG_S0_MIN_Y] <= MIN_RESET;
            cfg_reg[REG_S0_MAX_Y] <= MAX_RESET;
            cfg_reg[REG_S1_MIN_X] <= MIN_RESET;
            cfg_reg[REG_S1_MAX_X] <= MAX_RESET;
            cfg_reg[REG_S1_MIN_Y] <= MIN_RESET;
            cfg_reg[REG_S1_MAX_Y] <= MAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // whole pipeline advances unless the output beat is held
    assign adv      = !(valid_reg[AXIS_LATENCY-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[AXIS_LATENCY-2:0], in_valid};
    end

    always_comb
    begin
        x_in.pos = in_data.raw_x;
        y_in.pos = in_data.raw_y;
        if (in_data.stick_select)
        begin
            x_in.lo = cfg_reg[REG_S1_MIN_X];
            x_in.hi = cfg_reg[REG_S1_MAX_X];
            y_in.lo = cfg_reg[REG_S1_MIN_Y];
            y_in.hi = cfg_reg[REG_S1_MAX_Y];
        end
        else
        begin
            x_in.lo = cfg_reg[REG_S0_MIN_X];
            x_in.hi = cfg_reg[REG_S0_MAX_X];
            y_in.lo = cfg_reg[REG_S0_MIN_Y];
            y_in.hi = cfg_reg[REG_S0_MAX_Y];
        end
    end

    jdds_axis #(
        .SCALE_SHIFT(SCALE_SHIFT)
    ) u_axis_x (
        .clk     (clk),
        .en      (adv),
        .axis_in (x_in),
        .delta   (dx)
    );

    jdds_axis #(
        .SCALE_SHIFT(SCALE_SHIFT)
    ) u_axis_y (
        .clk     (clk),
        .en      (adv),
        .axis_in (y_in),
        .delta   (dy)
    );

    assign out_valid        = valid_reg[AXIS_LATENCY-1];
    assign out_data.delta_x = dx;
    assign out_data.delta_y = dy;

    `JDDS_ASSERT(a_no_min_x, clk, rst_n, !out_valid || out_data.delta_x != 8'sh80, "delta_x -128")
    `JDDS_ASSERT(a_no_min_y, clk, rst_n, !out_valid || out_data.delta_y != 8'sh80, "delta_y -128")
    `JDDS_ASSERT_NEXT(a_enter, clk, rst_n, in_valid && !in_stall, valid_reg[0], "beat lost at entry")
    `JDDS_ASSERT_NEXT(a_freeze, clk, rst_n, in_stall, $stable(valid_reg), "pipeline moved during stall")

endmodule

>>> sim/testbench.sv
// Self-checking testbench for joystick_delta_deadzone_scale: directed and random samples.
// Depends on jdds_pkg and the RTL top level; predicts deltas from its own calibration copy.
`timescale 1ns / 1ps
module testbench;
    import jdds_pkg::*;

    localparam int SCALE_SHIFT = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        CAL_ANY,
        CAL_TYPICAL,
        CAL_TINY,
        CAL_EXTREME,
        CAL_REVERSED
    } cal_shape_e;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_t              in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_t             out_data;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POS_W-1:0] cfg_data  = '0;

    logic             rx_gaps_on = 1'b0;
    logic             hold_start = 1'b0;
    bit               tx_gaps_on;

    logic [POS_W-1:0] cal [NUM_REGS];
    out_t             expected_deltas [$];
    int               errors      = 0;
    int               cycle_count = 0;

    joystick_delta_deadzone_scale #(
        .SCALE_SHIFT(SCALE_SHIFT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [15:0] zone_scale(input logic [15:0] span);
        if (span == 16'd0)
            return 16'd0;
        return 16'h8000 / span;
    endfunction

    function automatic void dead_zone_edges(input logic [15:0] lo, input logic [15:0] hi,
                                            output logic [15:0] tmin,
                                            output logic [15:0] tmax);
        logic [15:0] r;
        logic [15:0] d;
        r    = hi - lo;
        d    = r / 16'd3;
        tmin = (r >> 1) - d + lo;
        tmax = (r >> 1) + d + lo;
    endfunction

    function automatic logic [7:0] axis_deflection(input logic [15:0] pos,
                                                   input logic [15:0] lo,
                                                   input logic [15:0] hi);
        logic [15:0] tmin;
        logic [15:0] tmax;
        logic [15:0] p;
        logic [15:0] prod;
        logic [15:0] mag;
        dead_zone_edges(lo, hi, tmin, tmax);
        p = pos;
        if (p < tmin)
        begin
            if (p < lo)
                p = lo;
            prod = (tmin - p) * zone_scale(tmin - lo);
            mag  = prod >> SCALE_SHIFT;
            if (mag > 16'd127)
                mag = 16'd127;
            return 8'd0 - mag[7:0];
        end
        if (p > tmax)
        begin
            if (p > hi)
                p = hi;
            prod = (p - tmax) * zone_scale(hi - tmax);
            mag  = prod >> SCALE_SHIFT;
            if (mag > 16'd127)
                mag = 16'd127;
            return mag[7:0];
        end
        return 8'd0;
    endfunction

    function automatic out_t predict_deltas(input in_t s);
        out_t r;
        if (s.stick_select)
        begin
            r.delta_x = axis_deflection(s.raw_x, cal[REG_S1_MIN_X], cal[REG_S1_MAX_X]);
            r.delta_y = axis_deflection(s.raw_y, cal[REG_S1_MIN_Y], cal[REG_S1_MAX_Y]);
        end
        else
        begin
            r.delta_x = axis_deflection(s.raw_x, cal[REG_S0_MIN_X], cal[REG_S0_MAX_X]);
            r.delta_y = axis_deflection(s.raw_y, cal[REG_S0_MIN_Y], cal[REG_S0_MAX_Y]);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_deltas.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = expected_deltas.pop_front();
                if (out_data.delta_x !== want.delta_x)
                    report_mismatch($sformatf("delta_x got %0d want %0d",
                                              out_data.delta_x, want.delta_x));
                if (out_data.delta_y !== want.delta_y)
                    report_mismatch($sformatf("delta_y got %0d want %0d",
                                              out_data.delta_y, want.delta_y));
            end
        end
    end

    // ---------------------------------------------------------------- idling

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Receiver: long hold on request, otherwise random stall stretches while rx_gaps_on is set.
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (rx_gaps_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- driving

    task automatic send_sample(input bit sel, input logic [15:0] x, input logic [15:0] y);
        in_t beat;
        int  gap;
        beat.stick_select = sel;
        beat.raw_x        = x;
        beat.raw_y        = y;
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        expected_deltas.push_back(predict_deltas(beat));
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_deltas.size() != 0)
            @(posedge clk);
    endtask

    // Call only with nothing in flight; the enable drops again after each write.
    task automatic write_cal(input cfg_reg_e idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cal[idx] = value;
        @(posedge clk);
    endtask

    task automatic program_axis(input cfg_reg_e min_reg, input cfg_reg_e max_reg,
                                input cal_shape_e shape);
        logic [15:0] lo;
        logic [15:0] hi;
        case (shape)
            CAL_TYPICAL:
            begin
                lo = 16'($urandom_range(0, 4000));
                hi = lo + 16'($urandom_range(16, 20000));
            end
            CAL_TINY:
            begin
                lo = 16'($urandom);
                hi = lo + 16'($urandom_range(0, 8));
            end
            CAL_EXTREME:
            begin
                lo = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                hi = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            CAL_REVERSED:
            begin
                hi = 16'($urandom_range(0, 30000));
                lo = hi + 16'($urandom_range(1, 35000));
            end
            default:
            begin
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
        endcase
        write_cal(min_reg, lo);
        write_cal(max_reg, hi);
    endtask

    // Bias positions toward the calibration and dead zone edges.
    function automatic logic [15:0] pick_position(input logic [15:0] lo, input logic [15:0] hi);
        logic [15:0] tmin;
        logic [15:0] tmax;
        logic [15:0] jitter;
        dead_zone_edges(lo, hi, tmin, tmax);
        jitter = 16'($urandom_range(0, 4)) - 16'd2;
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'($urandom);
            3:       return tmin + jitter;
            4:       return tmax + jitter;
            5:       return lo + jitter;
            6:       return hi + jitter;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic send_random_sample();
        bit sel;
        logic [15:0] x;
        logic [15:0] y;
        sel = 1'($urandom_range(0, 1));
        if (sel)
        begin
            x = pick_position(cal[REG_S1_MIN_X], cal[REG_S1_MAX_X]);
            y = pick_position(cal[REG_S1_MIN_Y], cal[REG_S1_MAX_Y]);
        end
        else
        begin
            x = pick_position(cal[REG_S0_MIN_X], cal[REG_S0_MAX_X]);
            y = pick_position(cal[REG_S0_MIN_Y], cal[REG_S0_MAX_Y]);
        end
        send_sample(sel, x, y);
    endtask

    // ---------------------------------------------------------------- tests

    // Defaults: min 0, max 2048, dead zone 342..1706 on every axis.
    task automatic test_reset_calibration();
        send_sample(1'b0, 16'd0,     16'd2048);
        send_sample(1'b0, 16'd341,   16'd1707);
        send_sample(1'b0, 16'd342,   16'd1706);
        send_sample(1'b0, 16'd1024,  16'd1024);
        send_sample(1'b1, 16'd65535, 16'd0);
        send_sample(1'b1, 16'd2048,  16'd65535);
        send_sample(1'b1, 16'd100,   16'd1900);
        wait_for_results();
    endtask

    // Outer zone of zero width on the low side, one count wide on the high side.
    task automatic test_zero_width_zone();
        write_cal(REG_S0_MIN_X, 16'd10);
        write_cal(REG_S0_MAX_X, 16'd11);
        write_cal(REG_S1_MIN_Y, 16'd500);
        write_cal(REG_S1_MAX_Y, 16'd500);
        send_sample(1'b0, 16'd0,   16'd0);
        send_sample(1'b0, 16'd11,  16'd3000);
        send_sample(1'b1, 16'd499, 16'd499);
        send_sample(1'b1, 16'd501, 16'd501);
        wait_for_results();
    endtask

    // Minimum above maximum: thresholds wrap, products can overflow.
    task automatic test_reversed_calibration();
        write_cal(REG_S0_MIN_Y, 16'd60000);
        write_cal(REG_S0_MAX_Y, 16'd1000);
        write_cal(REG_S1_MIN_X, 16'd40000);
        write_cal(REG_S1_MAX_X, 16'd39990);
        send_sample(1'b0, 16'd0,     16'd0);
        send_sample(1'b0, 16'd30000, 16'd59000);
        send_sample(1'b1, 16'd39995, 16'd7);
        send_sample(1'b1, 16'd65535, 16'd65535);
        wait_for_results();
    endtask

    task automatic test_extreme_calibration();
        write_cal(REG_S0_MIN_X, 16'h0000);
        write_cal(REG_S0_MAX_X, 16'hFFFF);
        write_cal(REG_S0_MIN_Y, 16'hFFFF);
        write_cal(REG_S0_MAX_Y, 16'h0000);
        write_cal(REG_S1_MAX_X, 16'hFFFF);
        write_cal(REG_S1_MIN_Y, 16'hFFFF);
        write_cal(REG_S1_MAX_Y, 16'hFFFF);
        send_sample(1'b0, 16'h0000, 16'h0000);
        send_sample(1'b0, 16'hFFFF, 16'hFFFF);
        send_sample(1'b0, 16'd10921, 16'd32767);
        send_sample(1'b0, 16'd54613, 16'h8000);
        send_sample(1'b1, 16'h0000, 16'h0000);
        send_sample(1'b1, 16'hFFFF, 16'hFFFE);
        wait_for_results();
    endtask

    // Receiver holds off while the sender keeps offering, so the pipe fills.
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (50) send_random_sample();
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 10; phase++)
        begin
            wait_for_results();
            program_axis(REG_S0_MIN_X, REG_S0_MAX_X, cal_shape_e'($urandom_range(0, 4)));
            program_axis(REG_S0_MIN_Y, REG_S0_MAX_Y, cal_shape_e'($urandom_range(0, 4)));
            program_axis(REG_S1_MIN_X, REG_S1_MAX_X, cal_shape_e'($urandom_range(0, 4)));
            program_axis(REG_S1_MIN_Y, REG_S1_MAX_Y, cal_shape_e'($urandom_range(0, 4)));
            tx_gaps_on = (phase % 4 != 1) && (phase % 4 != 3);
            rx_gaps_on <= (phase % 4 != 2) && (phase % 4 != 3);
            repeat (120) send_random_sample();
        end
        wait_for_results();
    endtask

    initial
    begin
        cal[REG_S0_MIN_X] = MIN_RESET;
        cal[REG_S0_MAX_X] = MAX_RESET;
        cal[REG_S0_MIN_Y] = MIN_RESET;
        cal[REG_S0_MAX_Y] = MAX_RESET;
        cal[REG_S1_MIN_X] = MIN_RESET;
        cal[REG_S1_MAX_X] = MAX_RESET;
        cal[REG_S1_MIN_Y] = MIN_RESET;
        cal[REG_S1_MAX_Y] = MAX_RESET;
        tx_gaps_on = 1'b1;
        repeat (12) @(posedge clk);
        rst_n      <= 1'b1;
        rx_gaps_on <= 1'b1;
        @(posedge clk);

        test_reset_calibration();
        test_zero_width_zone();
        test_reversed_calibration();
        test_extreme_calibration();
        test_backpressure();
        test_random_traffic();

        // drain slack beyond the pipe
        repeat (40) @(posedge clk);
        if (errors == 0 && expected_deltas.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
